// ===== design/adpalu_pkg.sv =====
// Shared types and constants for the ARM data-processing ALU.
`timescale 1ns / 1ps

package adpalu_pkg;

    // Data-processing opcodes, instruction bits 24..21
    typedef enum logic [3:0] {
        OP_AND = 4'h0,
        OP_EOR = 4'h1,
        OP_SUB = 4'h2,
        OP_RSB = 4'h3,
        OP_ADD = 4'h4,
        OP_ADC = 4'h5,
        OP_SBC = 4'h6,
        OP_RSC = 4'h7,
        OP_TST = 4'h8,
        OP_TEQ = 4'h9,
        OP_CMP = 4'hA,
        OP_CMN = 4'hB,
        OP_ORR = 4'hC,
        OP_MOV = 4'hD,
        OP_BIC = 4'hE,
        OP_MVN = 4'hF
    } opcode_t;

    typedef logic [3:0] nzcv_t;
    typedef logic [2:0] cycles_t;

    localparam logic [3:0] PC_REG      = 4'hF;
    localparam cycles_t    CYC_BASE    = 3'd1;
    localparam cycles_t    CYC_PC_XTRA = 3'd2;

    // Input beat: instruction, first_operand, shifted_operand, shifter_carry
    localparam int IN_W       = 104;
    localparam int IN_INS_LO  = 0;
    localparam int IN_OP1_LO  = 32;
    localparam int IN_SHV_LO  = 64;
    localparam int IN_SHC_BIT = 96;

    // Output beat: result_value, write_back, flags_out, restore_status,
    // flush_request, diverted, cycle_count
    localparam int OUT_W = 48;

endpackage

// ===== design/arm_data_processing_alu.sv =====
// Top level of the ARM data-processing ALU.
// Executes one ARM data-processing instruction per beat: AND, EOR, SUB, RSB, ADD, ADC,
// SBC, RSC, TST, TEQ, CMP, CMN, ORR, MOV, BIC and MVN. The second operand is either
// the rotated 8-bit immediate (instruction bit 25 set) or the value shifted upstream
// together with its shifter carry. The block holds the NZCV flags; they reset to zero.
// Each beat passes an input register, one pass of adder and logic, and a result
// register. A result shows on m_tvalid once its beat has left the input register
// for the result register, and a new beat is taken every
// cycle while the result side keeps up. Flags written by one beat are seen by the
// next one. When the destination is the PC, data and logical opcodes leave the flags
// alone, raise flush_request, and raise restore_status if S is set. A compare opcode
// with S clear comes back as diverted with a zero result.
`timescale 1ns / 1ps

module arm_data_processing_alu (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] instruction, [63:32] first_operand, [95:64] shifted_operand,
    // [96] shifter_carry, [103:97] zero
    input  logic [adpalu_pkg::IN_W-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] result_value, [32] write_back, [36:33] flags_out, [37] restore_status,
    // [38] flush_request, [39] diverted, [42:40] cycle_count, [47:43] zero
    output logic [adpalu_pkg::OUT_W-1:0]  m_tdata
);

    // Input register
    logic        in_valid_reg;
    logic [31:0] ins_reg;
    logic [31:0] op1_reg;
    logic [31:0] shv_reg;
    logic        shc_reg;

    // Condition flags
    adpalu_pkg::nzcv_t flags_reg;
    adpalu_pkg::nzcv_t flags_next;

    // Result register
    logic                  out_valid_reg;
    logic [31:0]           res_reg;
    logic                  wb_reg;
    adpalu_pkg::nzcv_t     fout_reg;
    logic                  restore_reg;
    logic                  flush_reg;
    logic                  divert_reg;
    adpalu_pkg::cycles_t   cyc_reg;

    logic s_accept;
    logic advance;

    // Combinational execute
    adpalu_pkg::opcode_t opc;
    logic        s_bit;
    logic        imm_form;
    logic [4:0]  rot;
    logic [63:0] rot_pair;
    logic [31:0] imm_val;
    logic [31:0] op2;
    logic        shift_c;
    logic        cf;
    logic        vf;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic        add_cin;
    logic [32:0] sum;
    logic        v_add;
    logic        is_logic;
    logic        is_cmp;
    logic [31:0] alu_res;
    adpalu_pkg::nzcv_t   nzcv;
    logic        divert;
    logic        wb;
    logic        pcw;
    logic        upd;
    logic [31:0] res_next;
    adpalu_pkg::nzcv_t   fout_next;
    adpalu_pkg::cycles_t cyc_next;

    // Advance the input stage whenever the result register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ins_reg <= s_tdata[adpalu_pkg::IN_INS_LO +: 32];
            op1_reg <= s_tdata[adpalu_pkg::IN_OP1_LO +: 32];
            shv_reg <= s_tdata[adpalu_pkg::IN_SHV_LO +: 32];
            shc_reg <= s_tdata[adpalu_pkg::IN_SHC_BIT];
        end
    end

    always_comb begin
        opc      = adpalu_pkg::opcode_t'(ins_reg[24:21]);
        s_bit    = ins_reg[20];
        imm_form = ins_reg[25];
        cf       = flags_reg[1];
        vf       = flags_reg[0];

        // Rotated immediate: imm8 rotated right by twice the rotate field
        rot      = {ins_reg[11:8], 1'b0};
        rot_pair = {24'd0, ins_reg[7:0], 24'd0, ins_reg[7:0]} >> rot;
        imm_val  = rot_pair[31:0];

        if (imm_form) begin
            op2     = imm_val;
            shift_c = (rot == 5'd0) ? cf : imm_val[31];
        end else begin
            op2     = shv_reg;
            shift_c = shc_reg;
        end

        // One shared adder; subtraction adds the inverted operand
        add_a    = op1_reg;
        add_b    = op2;
        add_cin  = 1'b0;
        is_logic = 1'b0;
        unique case (opc) inside
            adpalu_pkg::OP_SUB, adpalu_pkg::OP_CMP: begin
                add_b   = ~op2;
                add_cin = 1'b1;
            end
            adpalu_pkg::OP_RSB: begin
                add_a   = op2;
                add_b   = ~op1_reg;
                add_cin = 1'b1;
            end
            adpalu_pkg::OP_ADD, adpalu_pkg::OP_CMN: begin
                add_cin = 1'b0;
            end
            adpalu_pkg::OP_ADC: begin
                add_cin = cf;
            end
            adpalu_pkg::OP_SBC: begin
                add_b   = ~op2;
                add_cin = cf;
            end
            adpalu_pkg::OP_RSC: begin
                add_a   = op2;
                add_b   = ~op1_reg;
                add_cin = cf;
            end
            default: begin
                is_logic = 1'b1;
            end
        endcase

        sum   = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
        v_add = (add_a[31] ~^ add_b[31]) & (add_a[31] ^ sum[31]);

        unique case (opc) inside
            adpalu_pkg::OP_AND, adpalu_pkg::OP_TST: alu_res = op1_reg & op2;
            adpalu_pkg::OP_EOR, adpalu_pkg::OP_TEQ: alu_res = op1_reg ^ op2;
            adpalu_pkg::OP_ORR:                     alu_res = op1_reg | op2;
            adpalu_pkg::OP_MOV:                     alu_res = op2;
            adpalu_pkg::OP_BIC:                     alu_res = op1_reg & ~op2;
            adpalu_pkg::OP_MVN:                     alu_res = ~op2;
            default:                                alu_res = sum[31:0];
        endcase

        nzcv = {alu_res[31], (alu_res == 32'd0),
                is_logic ? shift_c : sum[32],
                is_logic ? vf : v_add};

        is_cmp = (opc == adpalu_pkg::OP_TST) || (opc == adpalu_pkg::OP_TEQ)
              || (opc == adpalu_pkg::OP_CMP) || (opc == adpalu_pkg::OP_CMN);
        divert = is_cmp && !s_bit;
        wb     = !is_cmp;
        pcw    = wb && (ins_reg[15:12] == adpalu_pkg::PC_REG);
        upd    = is_cmp ? s_bit : (s_bit && !pcw);

        fout_next = upd ? nzcv : flags_reg;
        res_next  = divert ? 32'd0 : alu_res;
        cyc_next  = adpalu_pkg::CYC_BASE
                  + {2'd0, (!imm_form && ins_reg[4] && !divert)}
                  + (pcw ? adpalu_pkg::CYC_PC_XTRA : 3'd0);

        flags_next = (advance && upd) ? nzcv : flags_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg     <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            flags_reg <= flags_next;
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result while the consumer stalls
    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg     <= res_next;
            wb_reg      <= wb;
            fout_reg    <= fout_next;
            restore_reg <= pcw && s_bit;
            flush_reg   <= pcw;
            divert_reg  <= divert;
            cyc_reg     <= cyc_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, cyc_reg, divert_reg, flush_reg, restore_reg,
                       fout_reg, wb_reg, res_reg};

endmodule

// ===== design/adpalu_checker.sv =====
// Port-level checker for the ARM data-processing ALU, bound to the top level.
`timescale 1ns / 1ps

module adpalu_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [adpalu_pkg::IN_W-1:0]   s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [adpalu_pkg::OUT_W-1:0]  m_tdata
);

    // Cycle count stays within one to four
    a_cyc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[42:40] != 3'd0) && (m_tdata[42:40] <= 3'd4))
        else $error("cycle_count out of range");

    // Diverted beats have no effect
    a_divert: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[39]) |->
            (m_tdata[31:0] == 32'd0) && !m_tdata[32] && !m_tdata[37] && !m_tdata[38]
            && (m_tdata[42:40] == 3'd1))
        else $error("diverted beat with side effects");

    // A PC write-back flushes and costs the extra cycles; restore only with a flush
    a_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[38] || m_tdata[37])) |->
            m_tdata[38] && m_tdata[32] && (m_tdata[42:40] >= 3'd3))
        else $error("flush or restore inconsistent");

    // With the result side ready the input never stalls
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while result side ready");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind arm_data_processing_alu adpalu_checker u_adpalu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/dp_alu_checker.sv =====
// Stream monitor and result predictor for the ARM data-processing ALU.
`timescale 1ns / 1ps

module dp_alu_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [adpalu_pkg::IN_W-1:0]  s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [adpalu_pkg::OUT_W-1:0] m_tdata,
    output int                           mismatches,
    output int                           outstanding
);

    typedef struct packed {
        logic [31:0]         value;
        logic                write_back;
        adpalu_pkg::nzcv_t   flags;
        logic                restore_status;
        logic                flush_request;
        logic                diverted;
        adpalu_pkg::cycles_t cycles;
    } dp_result_t;

    localparam int MAX_PRINTED = 40;

    dp_result_t        expected_results[$];
    dp_result_t        seen_result;
    dp_result_t        due_result;
    adpalu_pkg::nzcv_t nzcv_state;
    int                result_index;

    initial begin
        mismatches   = 0;
        outstanding  = 0;
        result_index = 0;
        nzcv_state   = '0;
    end

    // a + b + cin, returning {N, Z, C, V} above the 32-bit sum
    function automatic logic [35:0] add_nzcv(input logic [31:0] a, input logic [31:0] b,
                                             input logic cin);
        logic [32:0] sum;
        logic        ovf;
        sum = {1'b0, a} + {1'b0, b} + {32'd0, cin};
        ovf = (a[31] == b[31]) && (sum[31] != a[31]);
        return {sum[31], sum[31:0] == 32'd0, sum[32], ovf, sum[31:0]};
    endfunction

    function automatic dp_result_t execute_dp(input logic [31:0] ins, input logic [31:0] op1,
                                              input logic [31:0] shv, input logic shc,
                                              input adpalu_pkg::nzcv_t flags);
        adpalu_pkg::opcode_t opc;
        logic                s_bit;
        logic                compare_op;
        logic                logical;
        logic                pc_write;
        logic                update;
        logic [3:0]          rd;
        logic [4:0]          rot;
        logic [31:0]         imm8;
        logic [31:0]         op2;
        logic [31:0]         res;
        logic                carry;
        adpalu_pkg::nzcv_t   next;
        dp_result_t          r;
        opc        = adpalu_pkg::opcode_t'(ins[24:21]);
        s_bit      = ins[20];
        rd         = ins[15:12];
        compare_op = (opc == adpalu_pkg::OP_TST) || (opc == adpalu_pkg::OP_TEQ)
                  || (opc == adpalu_pkg::OP_CMP) || (opc == adpalu_pkg::OP_CMN);
        r          = '0;
        r.cycles   = adpalu_pkg::CYC_BASE;
        if (compare_op && !s_bit) begin
            r.flags    = flags;
            r.diverted = 1'b1;
            return r;
        end
        if (ins[25]) begin
            imm8 = {24'd0, ins[7:0]};
            rot  = {ins[11:8], 1'b0};
            if (rot == 5'd0) begin
                op2   = imm8;
                carry = flags[1];
            end else begin
                op2   = (imm8 >> rot) | (imm8 << (32 - rot));
                carry = op2[31];
            end
        end else begin
            op2   = shv;
            carry = shc;
            if (ins[4]) r.cycles = r.cycles + 3'd1;
        end
        res     = '0;
        next    = flags;
        logical = 1'b0;
        case (opc)
            adpalu_pkg::OP_AND, adpalu_pkg::OP_TST: begin
                res = op1 & op2;  logical = 1'b1;
            end
            adpalu_pkg::OP_EOR, adpalu_pkg::OP_TEQ: begin
                res = op1 ^ op2;  logical = 1'b1;
            end
            adpalu_pkg::OP_SUB, adpalu_pkg::OP_CMP: {next, res} = add_nzcv(op1, ~op2, 1'b1);
            adpalu_pkg::OP_RSB:                     {next, res} = add_nzcv(op2, ~op1, 1'b1);
            adpalu_pkg::OP_ADD, adpalu_pkg::OP_CMN: {next, res} = add_nzcv(op1, op2, 1'b0);
            adpalu_pkg::OP_ADC: {next, res} = add_nzcv(op1, op2, flags[1]);
            adpalu_pkg::OP_SBC: {next, res} = add_nzcv(op1, ~op2, flags[1]);
            adpalu_pkg::OP_RSC: {next, res} = add_nzcv(op2, ~op1, flags[1]);
            adpalu_pkg::OP_ORR: begin res = op1 | op2;  logical = 1'b1; end
            adpalu_pkg::OP_MOV: begin res = op2;        logical = 1'b1; end
            adpalu_pkg::OP_BIC: begin res = op1 & ~op2; logical = 1'b1; end
            adpalu_pkg::OP_MVN: begin res = ~op2;       logical = 1'b1; end
        endcase
        // logical ops take the operand carry and keep V
        if (logical) next = {res[31], res == 32'd0, carry, flags[0]};
        pc_write = !compare_op && (rd == adpalu_pkg::PC_REG);
        update   = compare_op ? s_bit : (s_bit && rd != adpalu_pkg::PC_REG);
        r.value          = res;
        r.write_back     = !compare_op;
        r.flags          = update ? next : flags;
        r.restore_status = pc_write && s_bit;
        r.flush_request  = pc_write;
        if (pc_write) r.cycles = r.cycles + adpalu_pkg::CYC_PC_XTRA;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_PRINTED)
            $display("%0t: result %0d %s: got %h, expected %h", $realtime, result_index,
                     what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            nzcv_state = '0;
            expected_results.delete();
        end else begin
            // retire the output beat first so a same-edge push cannot be popped
            if (m_tvalid && m_tready) begin
                seen_result.value          = m_tdata[31:0];
                seen_result.write_back     = m_tdata[32];
                seen_result.flags          = m_tdata[36:33];
                seen_result.restore_status = m_tdata[37];
                seen_result.flush_request  = m_tdata[38];
                seen_result.diverted       = m_tdata[39];
                seen_result.cycles         = m_tdata[42:40];
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected beat", seen_result.value, 32'd0);
                end else begin
                    due_result = expected_results.pop_front();
                    if (seen_result.value != due_result.value)
                        report_mismatch("result_value", seen_result.value, due_result.value);
                    if (seen_result.write_back != due_result.write_back)
                        report_mismatch("write_back", 32'(seen_result.write_back),
                                        32'(due_result.write_back));
                    if (seen_result.flags != due_result.flags)
                        report_mismatch("flags_out", 32'(seen_result.flags),
                                        32'(due_result.flags));
                    if (seen_result.restore_status != due_result.restore_status)
                        report_mismatch("restore_status", 32'(seen_result.restore_status),
                                        32'(due_result.restore_status));
                    if (seen_result.flush_request != due_result.flush_request)
                        report_mismatch("flush_request", 32'(seen_result.flush_request),
                                        32'(due_result.flush_request));
                    if (seen_result.diverted != due_result.diverted)
                        report_mismatch("diverted", 32'(seen_result.diverted),
                                        32'(due_result.diverted));
                    if (seen_result.cycles != due_result.cycles)
                        report_mismatch("cycle_count", 32'(seen_result.cycles),
                                        32'(due_result.cycles));
                end
                result_index++;
            end
            if (s_tvalid && s_tready) begin
                due_result = execute_dp(s_tdata[adpalu_pkg::IN_INS_LO +: 32],
                                        s_tdata[adpalu_pkg::IN_OP1_LO +: 32],
                                        s_tdata[adpalu_pkg::IN_SHV_LO +: 32],
                                        s_tdata[adpalu_pkg::IN_SHC_BIT],
                                        nzcv_state);
                nzcv_state = due_result.flags;
                expected_results.push_back(due_result);
            end
        end
        outstanding = expected_results.size();
    end

endmodule

// ===== test/testbench.sv =====
// Top of the ARM data-processing ALU testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_BEATS  = 1250;
    localparam int HOLD_OFF_AT   = 400;   // beats sent before the long receiver stall
    localparam int HOLD_OFF_LEN  = 400;   // cycles of the long receiver stall
    localparam int DRAIN_CYCLES  = 8;     // extra wait after the last expected beat, as margin

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    // [31:0] instruction, [63:32] first_operand, [95:64] shifted_operand,
    // [96] shifter_carry, [103:97] zero
    logic [adpalu_pkg::IN_W-1:0]  s_tdata  = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    // [31:0] result_value, [32] write_back, [36:33] flags_out, [37] restore_status,
    // [38] flush_request, [39] diverted, [42:40] cycle_count, [47:43] zero
    logic [adpalu_pkg::OUT_W-1:0] m_tdata;

    int mismatches;
    int outstanding;
    int beats_sent = 0;
    int burst_left = 0;

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    arm_data_processing_alu i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    dp_alu_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Build a data-processing word: cond AL, given opcode, S, I, Rd and low 12 bits.
    // Rn is a don't-care for the block, so hold it at r1.
    function automatic logic [31:0] make_ins(input adpalu_pkg::opcode_t op,
                                             input logic s_bit, input logic imm,
                                             input logic [3:0] rd, input logic [11:0] low);
        return {4'hE, 2'b00, imm, op, s_bit, 4'h1, rd, low};
    endfunction

    // Operands lean toward the carry and overflow corners.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    // Offer one beat and hold it until accepted. Between bursts drop tvalid for a gap;
    // within a burst keep tvalid high so back-to-back beats go through.
    task automatic send_beat(input logic [31:0] ins, input logic [31:0] op1,
                             input logic [31:0] shv, input logic shc);
        s_tdata  <= {7'd0, shc, shv, op1, ins};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            // mostly short bursts, now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 30);
        end else begin
            burst_left--;
        end
    endtask

    // Receiver: segments of always-ready, coin-flip, periodic and mostly-ready tready,
    // plus one long hold-off once the sender is well under way, so the block backs up
    // and drops s_tready while beats keep being offered.
    initial begin
        int rx_mode;
        int rx_span;
        int rx_period;
        bit hold_off_done;
        hold_off_done = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!hold_off_done && beats_sent >= HOLD_OFF_AT) begin
                hold_off_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge aclk);
            end
            rx_mode   = $urandom_range(0, 3);
            rx_span   = $urandom_range(20, 150);
            rx_period = $urandom_range(2, 8);
            for (int i = 0; i < rx_span; i++) begin
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (i % rx_period) == 0;
                    default: m_tready <= $urandom_range(0, 9) != 0;
                endcase
                @(posedge aclk);
            end
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [31:0] ins;
        // hold reset, then release it on a clock edge
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed beats ---
        // immediate, rotate zero: carry comes from C (clear after reset), zero result
        send_beat(make_ins(adpalu_pkg::OP_MOV, 1'b1, 1'b1, 4'h2, 12'h000),
                  32'h0, 32'h0, 1'b0);
        // CMP 0 - 1: negative, borrow
        send_beat(make_ins(adpalu_pkg::OP_CMP, 1'b1, 1'b0, 4'h0, 12'h000),
                  32'h0, 32'h1, 1'b1);
        // CMN all-ones + 1: zero with carry out
        send_beat(make_ins(adpalu_pkg::OP_CMN, 1'b1, 1'b0, 4'h0, 12'h000),
                  32'hFFFF_FFFF, 32'h1, 1'b0);
        // rotate zero again, now C is set and must pass through
        send_beat(make_ins(adpalu_pkg::OP_MOV, 1'b1, 1'b1, 4'h3, 12'h0FF),
                  32'h0, 32'h0, 1'b0);
        // signed overflow on ADD
        send_beat(make_ins(adpalu_pkg::OP_ADD, 1'b1, 1'b0, 4'h4, 12'h000),
                  32'h7FFF_FFFF, 32'h1, 1'b0);
        // SUB equal operands: zero, carry set
        send_beat(make_ins(adpalu_pkg::OP_SUB, 1'b1, 1'b0, 4'h5, 12'h000),
                  32'h1234, 32'h1234, 1'b0);
        // ADC with carry in wraps to zero
        send_beat(make_ins(adpalu_pkg::OP_ADC, 1'b1, 1'b0, 4'h6, 12'h000),
                  32'hFFFF_FFFF, 32'h0, 1'b0);
        // SBC overflow from most negative
        send_beat(make_ins(adpalu_pkg::OP_SBC, 1'b1, 1'b0, 4'h7, 12'h000),
                  32'h8000_0000, 32'h1, 1'b0);
        // RSB 0 - 1
        send_beat(make_ins(adpalu_pkg::OP_RSB, 1'b1, 1'b0, 4'h8, 12'h000),
                  32'h1, 32'h0, 1'b0);
        // RSC with borrow pending
        send_beat(make_ins(adpalu_pkg::OP_RSC, 1'b1, 1'b0, 4'h9, 12'h000),
                  32'h0, 32'h0, 1'b1);
        // immediate rotated by 2: carry is bit 31 of the rotated value
        send_beat(make_ins(adpalu_pkg::OP_AND, 1'b1, 1'b1, 4'hA, 12'h103),
                  32'hFFFF_FFFF, 32'h0, 1'b0);
        // largest rotate, all-ones immediate byte
        send_beat(make_ins(adpalu_pkg::OP_EOR, 1'b1, 1'b1, 4'hB, 12'hFFF),
                  32'hAAAA_5555, 32'h0, 1'b0);
        // register-specified shift raises the cycle count
        send_beat(make_ins(adpalu_pkg::OP_ORR, 1'b1, 1'b0, 4'hC, 12'h010),
                  32'h0, 32'h8000_0000, 1'b1);
        send_beat(make_ins(adpalu_pkg::OP_BIC, 1'b1, 1'b0, 4'hD, 12'h000),
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_beat(make_ins(adpalu_pkg::OP_MVN, 1'b1, 1'b0, 4'hE, 12'h000),
                  32'h0, 32'h0, 1'b1);
        send_beat(make_ins(adpalu_pkg::OP_TST, 1'b1, 1'b0, 4'h0, 12'h000),
                  32'hF0F0_F0F0, 32'h0F0F_0F0F, 1'b1);
        send_beat(make_ins(adpalu_pkg::OP_TEQ, 1'b1, 1'b1, 4'h0, 12'h480),
                  32'h0800_0000, 32'h0, 1'b0);
        // compare opcodes with S clear are diverted, even toward the PC
        send_beat(make_ins(adpalu_pkg::OP_TST, 1'b0, 1'b0, 4'h0, 12'h010),
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_beat(make_ins(adpalu_pkg::OP_CMP, 1'b0, 1'b1, adpalu_pkg::PC_REG, 12'h0FF),
                  32'h0, 32'h0, 1'b0);
        // PC destination with S: restore status, flush, flags held
        send_beat(make_ins(adpalu_pkg::OP_ADD, 1'b1, 1'b0, adpalu_pkg::PC_REG, 12'h000),
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        // PC destination without S, register-specified shift: longest cycle count
        send_beat(make_ins(adpalu_pkg::OP_MOV, 1'b0, 1'b0, adpalu_pkg::PC_REG, 12'h010),
                  32'h0, 32'h0000_8000, 1'b1);
        // compare with S and PC destination still updates flags, no flush
        send_beat(make_ins(adpalu_pkg::OP_CMP, 1'b1, 1'b0, adpalu_pkg::PC_REG, 12'h000),
                  32'h8000_0000, 32'h1, 1'b0);
        // no S: flags held across arithmetic
        send_beat(make_ins(adpalu_pkg::OP_ADD, 1'b0, 1'b0, 4'h3, 12'h000),
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_beat(make_ins(adpalu_pkg::OP_SBC, 1'b0, 1'b0, 4'h4, 12'h000),
                  32'h0, 32'hFFFF_FFFF, 1'b0);
        send_beat(make_ins(adpalu_pkg::OP_ORR, 1'b0, 1'b1, 4'h5, 12'h480),
                  32'h1, 32'h0, 1'b0);

        // --- random beats: every instruction bit random, PC destination and rotate
        // zero made more frequent so the flush and C-passthrough paths stay busy ---
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            ins = $urandom;
            if ($urandom_range(0, 3) == 0) ins[15:12] = adpalu_pkg::PC_REG;
            if ($urandom_range(0, 4) == 0) ins[11:8] = 4'h0;
            send_beat(ins, pick_operand(), pick_operand(), 1'($urandom_range(0, 1)));
        end

        // drain: stop offering, wait for every expected beat, then let the pipe settle
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
